// File: rtl/stt_pkg.sv
package stt_pkg;

   localparam int OFFSET_BITS_DEFAULT = 20;
   localparam int LINE_BITS_DEFAULT   = 16;
   localparam int COLUMN_BITS_DEFAULT = 12;

   localparam int CHAR_BITS   = 8;
   localparam int KIND_BITS   = 5;
   localparam int MODE_BITS   = 4;
   localparam int CLASS_BITS  = 3;
   localparam int QUEUE_DEPTH = 4;

   // Scanner modes. The pair modes hold a character that may start a
   // two-character operator.
   localparam logic [MODE_BITS-1:0] MODE_IDLE   = 4'd0;
   localparam logic [MODE_BITS-1:0] MODE_MINUS  = 4'd1;
   localparam logic [MODE_BITS-1:0] MODE_BANG   = 4'd2;
   localparam logic [MODE_BITS-1:0] MODE_BAR    = 4'd3;
   localparam logic [MODE_BITS-1:0] MODE_AMP    = 4'd4;
   localparam logic [MODE_BITS-1:0] MODE_LT     = 4'd5;
   localparam logic [MODE_BITS-1:0] MODE_GT     = 4'd6;
   localparam logic [MODE_BITS-1:0] MODE_EQ     = 4'd7;
   localparam logic [MODE_BITS-1:0] MODE_NUMBER = 4'd8;
   localparam logic [MODE_BITS-1:0] MODE_IDENT  = 4'd9;
   localparam logic [MODE_BITS-1:0] MODE_STRING = 4'd10;

   // Token kinds.
   localparam logic [KIND_BITS-1:0] KIND_LPAREN    = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN    = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE    = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE    = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_PLUS      = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_MINUS     = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_ARROW     = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_STAR      = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_SLASH     = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_PERCENT   = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_BANG      = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_NE        = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_BAR       = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_OROR      = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_AMP       = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_ANDAND    = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_CARET     = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_LT        = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_LE        = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_GT        = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_GE        = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN    = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_EQEQ      = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_COMMA     = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_SEMICOLON = 5'd24;
   localparam logic [KIND_BITS-1:0] KIND_STRING    = 5'd25;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER    = 5'd26;
   localparam logic [KIND_BITS-1:0] KIND_IDENT     = 5'd27;
   localparam logic [KIND_BITS-1:0] KIND_EOF       = 5'd28;
   localparam logic [KIND_BITS-1:0] KIND_ERROR     = 5'd29;

   // Byte classes seen from the idle mode.
   localparam logic [CLASS_BITS-1:0] CLS_EOF    = 3'd0;
   localparam logic [CLASS_BITS-1:0] CLS_PAIR   = 3'd1;
   localparam logic [CLASS_BITS-1:0] CLS_SINGLE = 3'd2;
   localparam logic [CLASS_BITS-1:0] CLS_SPACE  = 3'd3;
   localparam logic [CLASS_BITS-1:0] CLS_QUOTE  = 3'd4;
   localparam logic [CLASS_BITS-1:0] CLS_DIGIT  = 3'd5;
   localparam logic [CLASS_BITS-1:0] CLS_ALPHA  = 3'd6;
   localparam logic [CLASS_BITS-1:0] CLS_ERROR  = 3'd7;

   // Character codes.
   localparam logic [CHAR_BITS-1:0] CH_NUL        = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_TAB        = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_LF         = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_CR         = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE      = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_BANG       = 8'h21;
   localparam logic [CHAR_BITS-1:0] CH_QUOTE      = 8'h22;
   localparam logic [CHAR_BITS-1:0] CH_PERCENT    = 8'h25;
   localparam logic [CHAR_BITS-1:0] CH_AMP        = 8'h26;
   localparam logic [CHAR_BITS-1:0] CH_LPAREN     = 8'h28;
   localparam logic [CHAR_BITS-1:0] CH_RPAREN     = 8'h29;
   localparam logic [CHAR_BITS-1:0] CH_STAR       = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CH_PLUS       = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_COMMA      = 8'h2C;
   localparam logic [CHAR_BITS-1:0] CH_MINUS      = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_SLASH      = 8'h2F;
   localparam logic [CHAR_BITS-1:0] CH_DIGIT_0    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_DIGIT_9    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_SEMICOLON  = 8'h3B;
   localparam logic [CHAR_BITS-1:0] CH_LT         = 8'h3C;
   localparam logic [CHAR_BITS-1:0] CH_EQ         = 8'h3D;
   localparam logic [CHAR_BITS-1:0] CH_GT         = 8'h3E;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A    = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CH_CARET      = 8'h5E;
   localparam logic [CHAR_BITS-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A    = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CH_LBRACE     = 8'h7B;
   localparam logic [CHAR_BITS-1:0] CH_BAR        = 8'h7C;
   localparam logic [CHAR_BITS-1:0] CH_RBRACE     = 8'h7D;

   typedef struct packed {
      logic [CLASS_BITS-1:0] cls;
      logic [KIND_BITS-1:0]  kind;
      logic [MODE_BITS-1:0]  mode;
   } idle_class_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] second;
      logic [KIND_BITS-1:0] single_kind;
      logic [KIND_BITS-1:0] double_kind;
   } pair_info_type;

   typedef struct packed {
      logic push_a;
      logic push_b;
   } push_type;

   // How a byte is treated when it arrives in the idle mode.
   function automatic idle_class_type classify(input logic [CHAR_BITS-1:0] b);
      idle_class_type r;
      r.cls  = CLS_ERROR;
      r.kind = KIND_ERROR;
      r.mode = MODE_IDLE;
      unique case (b) inside
         CH_NUL: begin
            r.cls  = CLS_EOF;
            r.kind = KIND_EOF;
         end
         CH_MINUS:     begin r.cls = CLS_PAIR; r.mode = MODE_MINUS; end
         CH_BANG:      begin r.cls = CLS_PAIR; r.mode = MODE_BANG;  end
         CH_BAR:       begin r.cls = CLS_PAIR; r.mode = MODE_BAR;   end
         CH_AMP:       begin r.cls = CLS_PAIR; r.mode = MODE_AMP;   end
         CH_LT:        begin r.cls = CLS_PAIR; r.mode = MODE_LT;    end
         CH_GT:        begin r.cls = CLS_PAIR; r.mode = MODE_GT;    end
         CH_EQ:        begin r.cls = CLS_PAIR; r.mode = MODE_EQ;    end
         CH_LPAREN:    begin r.cls = CLS_SINGLE; r.kind = KIND_LPAREN;    end
         CH_RPAREN:    begin r.cls = CLS_SINGLE; r.kind = KIND_RPAREN;    end
         CH_LBRACE:    begin r.cls = CLS_SINGLE; r.kind = KIND_LBRACE;    end
         CH_RBRACE:    begin r.cls = CLS_SINGLE; r.kind = KIND_RBRACE;    end
         CH_PLUS:      begin r.cls = CLS_SINGLE; r.kind = KIND_PLUS;      end
         CH_STAR:      begin r.cls = CLS_SINGLE; r.kind = KIND_STAR;      end
         CH_SLASH:     begin r.cls = CLS_SINGLE; r.kind = KIND_SLASH;     end
         CH_PERCENT:   begin r.cls = CLS_SINGLE; r.kind = KIND_PERCENT;   end
         CH_CARET:     begin r.cls = CLS_SINGLE; r.kind = KIND_CARET;     end
         CH_COMMA:     begin r.cls = CLS_SINGLE; r.kind = KIND_COMMA;     end
         CH_SEMICOLON: begin r.cls = CLS_SINGLE; r.kind = KIND_SEMICOLON; end
         CH_SPACE, CH_TAB, CH_CR, CH_LF: r.cls = CLS_SPACE;
         CH_QUOTE:     begin r.cls = CLS_QUOTE; r.mode = MODE_STRING; end
         [CH_DIGIT_0:CH_DIGIT_9]: begin
            r.cls  = CLS_DIGIT;
            r.mode = MODE_NUMBER;
         end
         [CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_UNDERSCORE: begin
            r.cls  = CLS_ALPHA;
            r.mode = MODE_IDENT;
         end
         default: r.cls = CLS_ERROR;
      endcase
      return r;
   endfunction

   // Second character and the two possible kinds for a pending pair mode.
   function automatic pair_info_type pair_info(input logic [MODE_BITS-1:0] mode);
      pair_info_type r;
      r = '{second: CH_NUL, single_kind: KIND_ERROR, double_kind: KIND_ERROR};
      unique case (mode)
         MODE_MINUS: r = '{second: CH_GT,  single_kind: KIND_MINUS,  double_kind: KIND_ARROW};
         MODE_BANG:  r = '{second: CH_EQ,  single_kind: KIND_BANG,   double_kind: KIND_NE};
         MODE_BAR:   r = '{second: CH_BAR, single_kind: KIND_BAR,    double_kind: KIND_OROR};
         MODE_AMP:   r = '{second: CH_AMP, single_kind: KIND_AMP,    double_kind: KIND_ANDAND};
         MODE_LT:    r = '{second: CH_EQ,  single_kind: KIND_LT,     double_kind: KIND_LE};
         MODE_GT:    r = '{second: CH_EQ,  single_kind: KIND_GT,     double_kind: KIND_GE};
         MODE_EQ:    r = '{second: CH_EQ,  single_kind: KIND_ASSIGN, double_kind: KIND_EQEQ};
         default:    r = '{second: CH_NUL, single_kind: KIND_ERROR,  double_kind: KIND_ERROR};
      endcase
      return r;
   endfunction

endpackage

// File: rtl/stt_token_queue.sv
module stt_token_queue #(
   parameter int DATA_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stt_pkg::push_type      push,
   input  logic [DATA_BITS-1:0]   data_a,
   input  logic [DATA_BITS-1:0]   data_b,
   input  logic                   pop,
   output logic                   out_valid,
   output logic [DATA_BITS-1:0]   out_data,
   output logic                   room
);
   import stt_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0]  mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0]   tail_next;

   assign tail_next = tail_ff + PTR_BITS'(1);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[head_ff];
   // Room for the two records that one byte may give.
   assign room      = (count_ff <= COUNT_BITS'(QUEUE_DEPTH - 2));

   always_comb begin
      head_in  = pop ? head_ff + PTR_BITS'(1) : head_ff;
      tail_in  = tail_ff + PTR_BITS'(push.push_a) + PTR_BITS'(push.push_b);
      count_in = count_ff + COUNT_BITS'(push.push_a) + COUNT_BITS'(push.push_b)
                 - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_a) begin
         mem_ff[tail_ff] <= data_a;
      end
      if (push.push_b) begin
         mem_ff[tail_next] <= data_b;
      end
   end

`ifndef ASSERT_OFF
   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.push_b |-> push.push_a)
      else $error("second record pushed without the first");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("token queue overflow");

   a_single_push_count: assert property (@(posedge clock) disable iff (reset)
      (push.push_a && !push.push_b && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("token queue count did not follow a single push");
`endif

endmodule

// File: rtl/stt_scan.sv
module stt_scan #(
   parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT,
   parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEFAULT,
   parameter int REC_BITS    = stt_pkg::KIND_BITS + 2 * (OFFSET_BITS + LINE_BITS
                                                         + COLUMN_BITS) + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [stt_pkg::CHAR_BITS-1:0] char_code,
   output stt_pkg::push_type             push,
   output logic [REC_BITS-1:0]           rec_a,
   output logic [REC_BITS-1:0]           rec_b
);
   import stt_pkg::*;

   localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

   logic [MODE_BITS-1:0]   mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [OFFSET_BITS-1:0] ts_off_ff, ts_off_in;
   logic [LINE_BITS-1:0]   ts_line_ff, ts_line_in;
   logic [COLUMN_BITS-1:0] ts_col_ff, ts_col_in;

   idle_class_type         ic;
   pair_info_type          pi;
   logic [COLUMN_BITS-1:0] col_cur;
   logic [OFFSET_BITS-1:0] off_prev;
   logic [OFFSET_BITS-1:0] off_adv;
   logic [LINE_BITS-1:0]   line_adv;
   logic [COLUMN_BITS-1:0] col_adv;
   logic                   is_pair, is_run, is_string, run_cont, flush;
   logic                   idle_emits, is_mark, restart;
   logic                   emit_a, emit_b;
   logic [REC_BITS-1:0]    idle_rec, flush_rec, rec_a_raw;

   function automatic logic [REC_BITS-1:0] make_rec(
      input logic [KIND_BITS-1:0]   k,
      input logic [OFFSET_BITS-1:0] sp,
      input logic [OFFSET_BITS-1:0] ep,
      input logic [LINE_BITS-1:0]   sl,
      input logic [LINE_BITS-1:0]   el,
      input logic [COLUMN_BITS-1:0] sc,
      input logic [COLUMN_BITS-1:0] ec);
      return {k, sp, ep, sl, el, sc, ec, 1'b0};
   endfunction

   assign ic = classify(char_code);
   assign pi = pair_info(mode_ff);

   always_comb begin
      col_cur   = (col_ff == COL_MAX) ? COL_MAX : col_ff + COLUMN_BITS'(1);
      off_prev  = (off_ff == '0) ? '0 : off_ff - OFFSET_BITS'(1);
      off_adv   = (off_ff == OFF_MAX) ? OFF_MAX : off_ff + OFFSET_BITS'(1);
      line_adv  = line_ff;
      col_adv   = col_cur;
      if (char_code == CH_LF) begin
         line_adv = (line_ff == LINE_MAX) ? LINE_MAX : line_ff + LINE_BITS'(1);
         col_adv  = '0;
      end

      is_pair   = (mode_ff >= MODE_MINUS) && (mode_ff <= MODE_EQ);
      is_run    = (mode_ff == MODE_NUMBER) || (mode_ff == MODE_IDENT);
      is_string = (mode_ff == MODE_STRING);
      run_cont  = (ic.cls == CLS_DIGIT) || ((mode_ff == MODE_IDENT) && (ic.cls == CLS_ALPHA));
      flush     = (is_pair && (char_code != pi.second)) || (is_run && !run_cont);

      idle_emits = (ic.cls == CLS_EOF) || (ic.cls == CLS_SINGLE) || (ic.cls == CLS_ERROR);
      is_mark    = (ic.cls == CLS_PAIR) || (ic.cls == CLS_QUOTE) || (ic.cls == CLS_DIGIT)
                   || (ic.cls == CLS_ALPHA);

      if (ic.cls == CLS_EOF) begin
         idle_rec = make_rec(KIND_EOF, '0, '0, '0, '0, '0, '0);
      end else begin
         idle_rec = make_rec(ic.kind, off_ff, off_ff, line_ff, line_ff, col_cur, col_cur);
      end

      if (is_pair) begin
         flush_rec = make_rec(pi.single_kind, ts_off_ff, ts_off_ff, ts_line_ff, ts_line_ff,
                              ts_col_ff, ts_col_ff);
      end else begin
         flush_rec = make_rec((mode_ff == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT,
                              ts_off_ff, off_prev, ts_line_ff, line_ff, ts_col_ff, col_ff);
      end

      mode_in    = mode_ff;
      off_in     = off_adv;
      line_in    = line_adv;
      col_in     = col_adv;
      ts_off_in  = ts_off_ff;
      ts_line_in = ts_line_ff;
      ts_col_in  = ts_col_ff;
      emit_a     = 1'b0;
      emit_b     = 1'b0;
      rec_a_raw  = idle_rec;
      restart    = 1'b0;

      if (is_string) begin
         if (char_code == CH_NUL) begin
            rec_a_raw = make_rec(KIND_ERROR, ts_off_ff, off_ff, ts_line_ff, line_ff,
                                 ts_col_ff, col_cur);
            emit_a    = 1'b1;
            restart   = 1'b1;
         end else if (char_code == CH_QUOTE) begin
            rec_a_raw = make_rec(KIND_STRING, ts_off_ff, off_ff, ts_line_ff, line_ff,
                                 ts_col_ff, col_cur);
            emit_a    = 1'b1;
            mode_in   = MODE_IDLE;
         end
      end else if (is_pair && !flush) begin
         rec_a_raw = make_rec(pi.double_kind, ts_off_ff, off_ff, ts_line_ff, ts_line_ff,
                              ts_col_ff, col_cur);
         emit_a    = 1'b1;
         mode_in   = MODE_IDLE;
      end else if (is_run && run_cont) begin
         mode_in = mode_ff;
      end else begin
         // Idle handling, possibly after flushing a pending token.
         if (flush) begin
            rec_a_raw = flush_rec;
            emit_a    = 1'b1;
            emit_b    = idle_emits;
         end else begin
            emit_a    = idle_emits;
         end
         mode_in = ic.mode;
         if (is_mark) begin
            ts_off_in  = off_ff;
            ts_line_in = line_ff;
            ts_col_in  = col_cur;
         end
         restart = (ic.cls == CLS_EOF);
      end

      if (restart) begin
         mode_in    = MODE_IDLE;
         off_in     = '0;
         line_in    = LINE_ONE;
         col_in     = '0;
         ts_off_in  = '0;
         ts_line_in = LINE_ONE;
         ts_col_in  = '0;
      end

      rec_a       = {rec_a_raw[REC_BITS-1:1], emit_a && !emit_b};
      rec_b       = {idle_rec[REC_BITS-1:1], 1'b1};
      push.push_a = fire && emit_a;
      push.push_b = fire && emit_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         off_ff     <= '0;
         line_ff    <= LINE_ONE;
         col_ff     <= '0;
         ts_off_ff  <= '0;
         ts_line_ff <= LINE_ONE;
         ts_col_ff  <= '0;
      end else if (fire) begin
         mode_ff    <= mode_in;
         off_ff     <= off_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         ts_off_ff  <= ts_off_in;
         ts_line_ff <= ts_line_in;
         ts_col_ff  <= ts_col_in;
      end
   end

`ifndef ASSERT_OFF
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      (line_ff != '0) && (ts_line_ff != '0))
      else $error("line counter reached zero");

   a_nul_restarts: assert property (@(posedge clock) disable iff (reset)
      (fire && (char_code == CH_NUL)) |=>
         ((off_ff == '0) && (line_ff == LINE_ONE) && (col_ff == '0)
          && (mode_ff == MODE_IDLE)))
      else $error("end of input did not restart the counters");

   a_eof_alone_or_last: assert property (@(posedge clock) disable iff (reset)
      (fire && (char_code == CH_NUL) && !is_string) |-> (emit_a && (emit_b || !flush)))
      else $error("end of input gave no end-of-file token");
`endif

endmodule

// File: rtl/source_text_tokenizer_core.sv
// Streaming lexical scanner: one source byte in, zero to two token records out.
// A byte waits in the input register; the scan logic then writes its records
// into the result queue.
// Throughput: one byte per cycle while the queue has room for two records;
// the four-entry queue has a single read port, so records leave one at a time.
// Reset (synchronous, active high) empties both stages and restarts the counters.
module source_text_tokenizer_core #(
   parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT,
   parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [stt_pkg::CHAR_BITS-1:0] req_char_code,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [stt_pkg::KIND_BITS-1:0] rsp_token_kind,
   output logic [OFFSET_BITS-1:0]        rsp_start_pos,
   output logic [OFFSET_BITS-1:0]        rsp_end_pos,
   output logic [LINE_BITS-1:0]          rsp_start_line,
   output logic [LINE_BITS-1:0]          rsp_end_line,
   output logic [COLUMN_BITS-1:0]        rsp_start_column,
   output logic [COLUMN_BITS-1:0]        rsp_end_column,
   output logic                          rsp_last_of_run
);
   import stt_pkg::*;

   // A token record is packed as {kind, start_pos, end_pos, start_line,
   // end_line, start_column, end_column, last_of_run}, last field lowest.
   localparam int REC_BITS = KIND_BITS + 2 * (OFFSET_BITS + LINE_BITS + COLUMN_BITS) + 1;
   localparam int EC_LSB   = 1;
   localparam int SC_LSB   = EC_LSB + COLUMN_BITS;
   localparam int EL_LSB   = SC_LSB + COLUMN_BITS;
   localparam int SL_LSB   = EL_LSB + LINE_BITS;
   localparam int EP_LSB   = SL_LSB + LINE_BITS;
   localparam int SP_LSB   = EP_LSB + OFFSET_BITS;
   localparam int K_LSB    = SP_LSB + OFFSET_BITS;

   // The input register holds one request byte. It is refilled in the same cycle
   // that the scan logic consumes it: one byte per cycle while the queue has room.
   logic                 in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0] in_char_ff;

   logic                 room;
   logic                 scan_fire;
   logic                 pop;
   push_type             push;
   logic [REC_BITS-1:0]  rec_a, rec_b, head_rec;

   // The held byte is scanned only when the queue can take both records that
   // it might give; otherwise the request side is held off.
   assign scan_fire   = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign pop         = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_code;
      end
   end

   // Mode and counter update for one byte, with the records it gives.
   stt_scan #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .REC_BITS    (REC_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .fire      (scan_fire),
      .char_code (in_char_ff),
      .push      (push),
      .rec_a     (rec_a),
      .rec_b     (rec_b)
   );

   // Result queue: parts the scan logic from the response side, so a stalled
   // response does not stop scanning until the queue runs short of room.
   stt_token_queue #(
      .DATA_BITS (REC_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_a    (rec_a),
      .data_b    (rec_b),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (head_rec),
      .room      (room)
   );

   assign rsp_token_kind   = head_rec[K_LSB +: KIND_BITS];
   assign rsp_start_pos    = head_rec[SP_LSB +: OFFSET_BITS];
   assign rsp_end_pos      = head_rec[EP_LSB +: OFFSET_BITS];
   assign rsp_start_line   = head_rec[SL_LSB +: LINE_BITS];
   assign rsp_end_line     = head_rec[EL_LSB +: LINE_BITS];
   assign rsp_start_column = head_rec[SC_LSB +: COLUMN_BITS];
   assign rsp_end_column   = head_rec[EC_LSB +: COLUMN_BITS];
   assign rsp_last_of_run  = head_rec[0];

`ifndef ASSERT_OFF
   a_scan_has_room: assert property (@(posedge clock) disable iff (reset)
      (push.push_a || push.push_b) |-> scan_fire)
      else $error("records pushed without a scanned byte");

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !scan_fire) |=> (in_valid_ff && $stable(in_char_ff)))
      else $error("held request byte lost while waiting for room");

   a_kind_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_token_kind <= KIND_ERROR))
      else $error("token kind out of range");
`endif

endmodule
